// ===== hdl/fsbp_pkg.sv =====
// shared constants, types and codes for the fractional shift bilinear plane
`default_nettype none

package fsbp_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int DATA_BITS  = 16;
   localparam int FRAC_BITS  = 8;
   localparam int SHIFT_BITS = 16;

   localparam int ROW_BITS  = $clog2(MAX_ROWS);
   localparam int COL_BITS  = $clog2(MAX_COLS);
   localparam int SIZE_BITS = 7;
   localparam int IDX_BITS  = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
   localparam int INT_BITS  = SHIFT_BITS - FRAC_BITS;
   // signed neighbour position: index plus whole part of the offset, plus one
   localparam int POS_BITS  = ((IDX_BITS + 1 > INT_BITS) ? IDX_BITS + 1 : INT_BITS) + 1;

   localparam int FW_BITS   = FRAC_BITS + 1;
   localparam int WGT_BITS  = 2 * FRAC_BITS + 1;
   localparam int PROD_BITS = DATA_BITS + WGT_BITS + 1;
   localparam int ACC_BITS  = PROD_BITS + 2;
   localparam int RES_BITS  = ACC_BITS - 2 * FRAC_BITS;

   localparam int BANK_DEPTH     = (MAX_ROWS * MAX_COLS) / 4;
   localparam int BANK_ADDR_BITS = (ROW_BITS - 1) + (COL_BITS - 1);

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [SIZE_BITS-1:0] SIZE_MAX_ROWS = SIZE_BITS'(MAX_ROWS);
   localparam logic [SIZE_BITS-1:0] SIZE_MAX_COLS = SIZE_BITS'(MAX_COLS);
   localparam logic [FW_BITS-1:0]   FRAC_ONE      = FW_BITS'(1 << FRAC_BITS);

   localparam logic signed [RES_BITS-1:0] SAT_HI = RES_BITS'((1 << (DATA_BITS - 1)) - 1);
   localparam logic signed [RES_BITS-1:0] SAT_LO = -SAT_HI - RES_BITS'(1);

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PLANE_HEIGHT = 2'd0,
      CSR_PLANE_WIDTH  = 2'd1,
      CSR_ROW_SHIFT    = 2'd2,
      CSR_COL_SHIFT    = 2'd3
   } csr_type;

   typedef struct packed {
      logic                        en;
      logic [BANK_ADDR_BITS-1:0]   addr;
      logic signed [DATA_BITS-1:0] data;
   } bank_wr_type;

   typedef struct packed {
      logic                      en;
      logic [BANK_ADDR_BITS-1:0] addr;
   } bank_rd_type;

endpackage

`default_nettype wire

// ===== hdl/fsbp_bank.sv =====
// one parity bank of the pixel plane, registered read
`default_nettype none

module fsbp_bank (
   input  wire logic                                 clock,
   input  wire fsbp_pkg::bank_wr_type                wr,
   input  wire fsbp_pkg::bank_rd_type                rd,
   output logic signed [fsbp_pkg::DATA_BITS-1:0]     rd_data
);
   import fsbp_pkg::*;

   logic signed [DATA_BITS-1:0] mem_ff [BANK_DEPTH];
   logic signed [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/fractional_shift_bilinear_plane.sv =====
// a query word goes through stages 1 to 6 and is shown on rsp_ from stage 6, load words give none
// throughput: one word per cycle; the six-stage pipe moves as a whole and stalls only
//    while a finished word waits on rsp_ready
// the plane sits in four parity banks so all four neighbours are read in the same cycle
// reset clears the stage valid bits and the registers (size 64 x 64, shifts 0);
//    the plane store is not cleared and must be loaded before it is queried
`default_nettype none

module fractional_shift_bilinear_plane (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [fsbp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [fsbp_pkg::CSR_DATA_BITS-1:0]     csr_data,

   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_mode,
   input  wire logic signed [fsbp_pkg::DATA_BITS-1:0]  req_pixel,
   input  wire logic [fsbp_pkg::ROW_BITS-1:0]          req_row,
   input  wire logic [fsbp_pkg::COL_BITS-1:0]          req_col,

   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [fsbp_pkg::DATA_BITS-1:0]       rsp_value,
   output logic [fsbp_pkg::ROW_BITS-1:0]               rsp_out_row,
   output logic [fsbp_pkg::COL_BITS-1:0]               rsp_out_col
);
   import fsbp_pkg::*;

   // configuration
   logic [SIZE_BITS-1:0]         height_ff, width_ff;
   logic signed [SHIFT_BITS-1:0] row_shift_ff, col_shift_ff;

   logic advance, req_accept;

   // stage 1: neighbour origin
   logic                        s1_valid_ff;
   logic [ROW_BITS-1:0]         s1_row_ff;
   logic [COL_BITS-1:0]         s1_col_ff;
   logic signed [POS_BITS-1:0]  s1_r0_ff, s1_c0_ff;
   logic signed [POS_BITS-1:0]  s1_r0_in, s1_c0_in;

   // stage 2: bank read, bounds and weights
   logic                        s2_valid_ff;
   logic [ROW_BITS-1:0]         s2_row_ff;
   logic [COL_BITS-1:0]         s2_col_ff;
   logic                        s2_rpar_ff, s2_cpar_ff;
   logic [1:0]                  s2_rok_ff, s2_cok_ff, s2_rok_in, s2_cok_in;
   logic [WGT_BITS-1:0]         s2_wgt_ff [4];
   logic [WGT_BITS-1:0]         s2_wgt_in [4];

   // stage 3: weighted neighbours
   logic                        s3_valid_ff;
   logic [ROW_BITS-1:0]         s3_row_ff;
   logic [COL_BITS-1:0]         s3_col_ff;
   logic signed [PROD_BITS-1:0] s3_prod_ff [4];
   logic signed [PROD_BITS-1:0] s3_prod_in [4];

   // stage 4: pair sums
   logic                        s4_valid_ff;
   logic [ROW_BITS-1:0]         s4_row_ff;
   logic [COL_BITS-1:0]         s4_col_ff;
   logic signed [ACC_BITS-1:0]  s4_sum_ff [2];

   // stage 5: full sum
   logic                        s5_valid_ff;
   logic [ROW_BITS-1:0]         s5_row_ff;
   logic [COL_BITS-1:0]         s5_col_ff;
   logic signed [ACC_BITS-1:0]  s5_acc_ff;

   // stage 6: output word
   logic                        s6_valid_ff;
   logic [ROW_BITS-1:0]         s6_row_ff;
   logic [COL_BITS-1:0]         s6_col_ff;
   logic signed [DATA_BITS-1:0] s6_value_ff, s6_value_in;

   bank_wr_type                 bank_wr [4];
   bank_rd_type                 bank_rd [4];
   logic signed [DATA_BITS-1:0] bank_data [4];

   logic signed [POS_BITS-1:0]  r1, c1;
   logic [SIZE_BITS-1:0]        h_lim, w_lim;
   logic [FW_BITS-1:0]          wr_frac [2];
   logic [FW_BITS-1:0]          wc_frac [2];
   logic signed [RES_BITS-1:0]  shifted;

   assign advance    = !s6_valid_ff || rsp_ready;
   assign req_ready  = advance;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= SIZE_MAX_ROWS;
         width_ff     <= SIZE_MAX_COLS;
         row_shift_ff <= '0;
         col_shift_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PLANE_HEIGHT: height_ff    <= csr_data[SIZE_BITS-1:0];
            CSR_PLANE_WIDTH:  width_ff     <= csr_data[SIZE_BITS-1:0];
            CSR_ROW_SHIFT:    row_shift_ff <= $signed(csr_data[SHIFT_BITS-1:0]);
            CSR_COL_SHIFT:    col_shift_ff <= $signed(csr_data[SHIFT_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // stage 1: origin = position + floor of the offset
   assign s1_r0_in = $signed(POS_BITS'(req_row))
                   + POS_BITS'($signed(row_shift_ff[SHIFT_BITS-1:FRAC_BITS]));
   assign s1_c0_in = $signed(POS_BITS'(req_col))
                   + POS_BITS'($signed(col_shift_ff[SHIFT_BITS-1:FRAC_BITS]));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept && (req_mode == MODE_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_row_ff <= req_row;
         s1_col_ff <= req_col;
         s1_r0_ff  <= s1_r0_in;
         s1_c0_ff  <= s1_c0_in;
      end
   end

   // stage 2 logic: bank addresses, bounds, weights
   assign r1    = s1_r0_ff + POS_BITS'(1);
   assign c1    = s1_c0_ff + POS_BITS'(1);
   assign h_lim = (height_ff > SIZE_MAX_ROWS) ? SIZE_MAX_ROWS : height_ff;
   assign w_lim = (width_ff > SIZE_MAX_COLS) ? SIZE_MAX_COLS : width_ff;

   always_comb begin
      s2_rok_in[0] = !s1_r0_ff[POS_BITS-1] && (s1_r0_ff < $signed(POS_BITS'(h_lim)));
      s2_rok_in[1] = !r1[POS_BITS-1]       && (r1       < $signed(POS_BITS'(h_lim)));
      s2_cok_in[0] = !s1_c0_ff[POS_BITS-1] && (s1_c0_ff < $signed(POS_BITS'(w_lim)));
      s2_cok_in[1] = !c1[POS_BITS-1]       && (c1       < $signed(POS_BITS'(w_lim)));
      wr_frac[0] = FRAC_ONE - FW_BITS'(row_shift_ff[FRAC_BITS-1:0]);
      wr_frac[1] = FW_BITS'(row_shift_ff[FRAC_BITS-1:0]);
      wc_frac[0] = FRAC_ONE - FW_BITS'(col_shift_ff[FRAC_BITS-1:0]);
      wc_frac[1] = FW_BITS'(col_shift_ff[FRAC_BITS-1:0]);
      for (int n = 0; n < 4; n++) begin
         s2_wgt_in[n] = WGT_BITS'(wr_frac[n / 2]) * WGT_BITS'(wc_frac[n % 2]);
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic                       bpr, bpc;
      logic signed [POS_BITS-1:0] rsel, csel;

      assign bpr  = 1'(b / 2);
      assign bpc  = 1'(b % 2);
      // the row of r0 and r0+1 whose parity matches this bank
      assign rsel = (s1_r0_ff[0] == bpr) ? s1_r0_ff : r1;
      assign csel = (s1_c0_ff[0] == bpc) ? s1_c0_ff : c1;

      assign bank_rd[b].en   = advance;
      assign bank_rd[b].addr = {rsel[ROW_BITS-1:1], csel[COL_BITS-1:1]};

      assign bank_wr[b].en   = req_accept && (req_mode == MODE_LOAD)
                             && (req_row[0] == bpr) && (req_col[0] == bpc);
      assign bank_wr[b].addr = {req_row[ROW_BITS-1:1], req_col[COL_BITS-1:1]};
      assign bank_wr[b].data = req_pixel;

      fsbp_bank u_bank (
         .clock   (clock),
         .wr      (bank_wr[b]),
         .rd      (bank_rd[b]),
         .rd_data (bank_data[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_rpar_ff <= s1_r0_ff[0];
         s2_cpar_ff <= s1_c0_ff[0];
         s2_rok_ff  <= s2_rok_in;
         s2_cok_ff  <= s2_cok_in;
         s2_wgt_ff  <= s2_wgt_in;
      end
   end

   // stage 3: pick each neighbour from its bank, zero outside the plane, weight it
   always_comb begin
      logic [1:0]                  bsel;
      logic signed [DATA_BITS-1:0] pix;
      for (int n = 0; n < 4; n++) begin
         bsel = {s2_rpar_ff ^ 1'(n / 2), s2_cpar_ff ^ 1'(n % 2)};
         pix  = (s2_rok_ff[n / 2] && s2_cok_ff[n % 2]) ? bank_data[bsel] : '0;
         s3_prod_in[n] = PROD_BITS'(pix) * $signed({1'b0, s2_wgt_ff[n]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // floor shift then clamp to the pixel range
   assign shifted = RES_BITS'(s5_acc_ff >>> (2 * FRAC_BITS));

   always_comb begin
      if (shifted > SAT_HI) begin
         s6_value_in = DATA_BITS'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         s6_value_in = DATA_BITS'(SAT_LO);
      end else begin
         s6_value_in = DATA_BITS'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_row_ff    <= s2_row_ff;
         s3_col_ff    <= s2_col_ff;
         s3_prod_ff   <= s3_prod_in;
         s4_row_ff    <= s3_row_ff;
         s4_col_ff    <= s3_col_ff;
         s4_sum_ff[0] <= ACC_BITS'(s3_prod_ff[0]) + ACC_BITS'(s3_prod_ff[1]);
         s4_sum_ff[1] <= ACC_BITS'(s3_prod_ff[2]) + ACC_BITS'(s3_prod_ff[3]);
         s5_row_ff    <= s4_row_ff;
         s5_col_ff    <= s4_col_ff;
         s5_acc_ff    <= s4_sum_ff[0] + s4_sum_ff[1];
         s6_row_ff    <= s5_row_ff;
         s6_col_ff    <= s5_col_ff;
         s6_value_ff  <= s6_value_in;
      end
   end

   assign rsp_valid   = s6_valid_ff;
   assign rsp_value   = s6_value_ff;
   assign rsp_out_row = s6_row_ff;
   assign rsp_out_col = s6_col_ff;

   // a waiting word holds the whole pipe and the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output word stalled");

   a_query_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_QUERY) |=> s1_valid_ff)
      else $error("accepted query word missing from stage 1");

   a_load_no_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_LOAD) |=> !s1_valid_ff)
      else $error("load word entered the result pipe");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff,
                            s5_valid_ff, s6_valid_ff}))
      else $error("pipe moved during stall");

endmodule

`default_nettype wire
